### hw/rtl/lpft_pkg.sv
// lpft_pkg: shared types, register indexes and the quarter-wave sine series
// for the lidar point filter. No dependencies; compiled first.

package lpft_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_MIN_RANGE  = 3'd0;
  localparam logic [2:0] CFG_MAX_RANGE  = 3'd1;
  localparam logic [2:0] CFG_BOX_X      = 3'd2;
  localparam logic [2:0] CFG_BOX_Y      = 3'd3;
  localparam logic [2:0] CFG_ROT_XY     = 3'd4;
  localparam logic [2:0] CFG_ROT_Z      = 3'd5;
  localparam logic [2:0] CFG_OFFSET     = 3'd6;

  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 64;

  // reset values
  localparam logic [15:0] RST_MIN_RANGE = 16'd100;
  localparam logic [15:0] RST_MAX_RANGE = 16'hFFFF;
  localparam logic [63:0] RST_ROT_XY    = 64'h4000_0000_0000_4000;

  // angle handling, 0.01 degree units
  localparam logic [15:0] FULL_TURN     = 16'd36000;
  localparam logic [15:0] QUARTER_TURN  = 16'd9000;
  localparam logic [15:0] HALF_TURN     = 16'd18000;
  localparam logic [15:0] THREE_QUARTER = 16'd27000;

  // quarter-wave sine rom, q0.15 magnitudes for 0..90.00 degrees
  localparam int unsigned SINE_DEPTH    = 9001;
  localparam int unsigned SINE_IDX_W    = 14;
  localparam int unsigned SINE_W        = 15;

  // datapath widths
  localparam int unsigned XY_W          = 33;  // d * sin, exact q15 mm
  localparam int unsigned PROD_W        = 49;  // q2.14 coefficient times XY_W
  localparam int unsigned SUM_W         = 51;  // two products plus offset
  localparam int unsigned FRAC_W        = 29;
  localparam int unsigned POS_W         = SUM_W - FRAC_W;

  localparam logic [63:0] PI_Q30        = 64'd3373259426;
  localparam logic [63:0] ONE_Q30       = 64'd1 << 30;

  typedef struct packed {
    logic [7:0] reflectance;
    logic [9:0] point_index;
    logic       last_point;
  } side_t;

  // sin(x) by its series up to the x^11 term in q30, rounded to q15
  function automatic logic [SINE_W-1:0] sine_q15(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (64'(k) * PI_Q30) / 64'd18000;
    x2 = (x * x) >> 30;
    t  = ONE_Q30 - x2 / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[SINE_W-1:0];
  endfunction

endpackage

### hw/rtl/lpft_if.sv
// lpft_if: valid/ready channel interfaces for the lidar point filter
// (input returns, result points, configuration writes). Depends on lpft_pkg.

interface lpft_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] distance_mm;
  logic [15:0] angle_centideg;
  logic [7:0]  reflectance;
  logic [9:0]  point_index;
  logic        last_point;

  modport source (output valid, distance_mm, angle_centideg, reflectance,
                  point_index, last_point, input ready);
  modport sink   (input valid, distance_mm, angle_centideg, reflectance,
                  point_index, last_point, output ready);
endinterface

interface lpft_out_if;
  logic               valid;
  logic               ready;
  logic               keep;
  logic signed [15:0] pos_x_mm;
  logic signed [15:0] pos_y_mm;
  logic signed [15:0] pos_z_mm;
  logic [7:0]         reflectance_out;
  logic [9:0]         index_out;
  logic               last_out;

  modport source (output valid, keep, pos_x_mm, pos_y_mm, pos_z_mm,
                  reflectance_out, index_out, last_out, input ready);
  modport sink   (input valid, keep, pos_x_mm, pos_y_mm, pos_z_mm,
                  reflectance_out, index_out, last_out, output ready);
endinterface

interface lpft_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lpft_pkg::CFG_IDX_W-1:0]   wr_index;
  logic [lpft_pkg::CFG_DATA_W-1:0]  wr_data;

  modport source (output valid, wr_index, wr_data, input ready);
  modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

### hw/rtl/lidar_point_filter_transform_top.sv
// lidar_point_filter_transform_top: range filter, polar to cartesian conversion,
// mounting transform and body-box filter. Depends on lpft_pkg and lpft_if.
//
// Usage:
//   in_pt  takes one lidar return per request (distance, angle, reflectance,
//          point index, last flag). Every request gives exactly one result.
//   out_pt gives keep, x/y/z in mm saturated to 16 bits, and the pass-through
//          fields. A range-dropped return has keep low and zero positions; a
//          point inside the body box has keep low and its real positions.
//   cfg_wr writes one register per request, always ready; write only while
//          no request is in flight.
// Throughput, while out_pt does not stall, is one request per cycle: an
// eight-stage pipeline with a valid bit per stage, the 9001-entry sine rom
// read in one stage with two registered read ports, the six coefficient
// multiplies in another.
// When out_pt stalls, each stage still advances into an empty stage after it,
// so bubbles are squeezed out and the input keeps taking requests until the
// pipeline is full; nothing is lost or repeated.
// Reset empties the pipeline and loads the register defaults (identity
// rotation, no offset, empty box, range 100 to 65535 mm).

module lidar_point_filter_transform_top (
  input  logic          clk,
  input  logic          rst_n,
  lpft_in_if.sink       in_pt,
  lpft_out_if.source    out_pt,
  lpft_cfg_if.sink      cfg_wr
);

  localparam int unsigned NSTG = 8;

  typedef struct packed {
    logic                              neg;
    logic [lpft_pkg::SINE_IDX_W-1:0]   idx;
  } quad_t;

  // fold an angle in 0..35999 onto the quarter wave
  function automatic quad_t quad_of(logic [15:0] a);
    quad_t  q;
    logic [15:0] r;
    if (a < lpft_pkg::QUARTER_TURN) begin
      q.neg = 1'b0;
      r     = a;
    end else if (a < lpft_pkg::HALF_TURN) begin
      q.neg = 1'b0;
      r     = lpft_pkg::HALF_TURN - a;
    end else if (a < lpft_pkg::THREE_QUARTER) begin
      q.neg = 1'b1;
      r     = a - lpft_pkg::HALF_TURN;
    end else begin
      q.neg = 1'b1;
      r     = lpft_pkg::FULL_TURN - a;
    end
    q.idx = r[lpft_pkg::SINE_IDX_W-1:0];
    return q;
  endfunction

  // translation in q29 with the rounding half already ored in
  function automatic logic signed [lpft_pkg::SUM_W-1:0] bias_of(logic [15:0] t);
    return {{(lpft_pkg::SUM_W - 16 - lpft_pkg::FRAC_W){t[15]}}, t,
            1'b1, {(lpft_pkg::FRAC_W - 1){1'b0}}};
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [lpft_pkg::POS_W-1:0] v);
    logic [15:0] r;
    if (&v[lpft_pkg::POS_W-1:15] || ~|v[lpft_pkg::POS_W-1:15]) begin
      r = v[15:0];
    end else if (v[lpft_pkg::POS_W-1]) begin
      r = 16'h8000;
    end else begin
      r = 16'h7FFF;
    end
    return signed'(r);
  endfunction

  // ---------------------------------------------------------------------------
  // quarter-wave sine rom, constant contents

  logic [lpft_pkg::SINE_W-1:0] sine_rom [lpft_pkg::SINE_DEPTH];

  initial begin
    for (int unsigned k = 0; k < lpft_pkg::SINE_DEPTH; k++) begin
      sine_rom[k] = lpft_pkg::sine_q15(k);
    end
  end

  // ---------------------------------------------------------------------------
  // configuration registers

  logic [15:0] min_range_r;
  logic [15:0] max_range_r;
  logic [31:0] box_x_r;
  logic [31:0] box_y_r;
  logic [63:0] rot_xy_r;
  logic [31:0] rot_z_r;
  logic [47:0] offset_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_range_r <= lpft_pkg::RST_MIN_RANGE;
      max_range_r <= lpft_pkg::RST_MAX_RANGE;
      box_x_r     <= '0;
      box_y_r     <= '0;
      rot_xy_r    <= lpft_pkg::RST_ROT_XY;
      rot_z_r     <= '0;
      offset_r    <= '0;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.wr_index)
        lpft_pkg::CFG_MIN_RANGE: min_range_r <= cfg_wr.wr_data[15:0];
        lpft_pkg::CFG_MAX_RANGE: max_range_r <= cfg_wr.wr_data[15:0];
        lpft_pkg::CFG_BOX_X:     box_x_r     <= cfg_wr.wr_data[31:0];
        lpft_pkg::CFG_BOX_Y:     box_y_r     <= cfg_wr.wr_data[31:0];
        lpft_pkg::CFG_ROT_XY:    rot_xy_r    <= cfg_wr.wr_data;
        lpft_pkg::CFG_ROT_Z:     rot_z_r     <= cfg_wr.wr_data[31:0];
        lpft_pkg::CFG_OFFSET:    offset_r    <= cfg_wr.wr_data[47:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stage valid bits and advance chain

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || out_pt.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_pt.ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_pt.valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 0: range window, angle reduced into one turn

  logic               s0_rok_r;
  logic [15:0]        s0_dist_r;
  logic [15:0]        s0_asin_r;
  lpft_pkg::side_t    s0_side_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_rok_r  <= (in_pt.distance_mm >= min_range_r) &&
                   (in_pt.distance_mm <= max_range_r);
      s0_dist_r <= in_pt.distance_mm;
      s0_asin_r <= (in_pt.angle_centideg >= lpft_pkg::FULL_TURN) ?
                   in_pt.angle_centideg - lpft_pkg::FULL_TURN : in_pt.angle_centideg;
      s0_side_r <= '{reflectance: in_pt.reflectance,
                     point_index: in_pt.point_index,
                     last_point:  in_pt.last_point};
    end
  end

  // stage 1: cosine angle, a quarter turn ahead
  logic               s1_rok_r;
  logic [15:0]        s1_dist_r;
  logic [15:0]        s1_asin_r;
  logic [15:0]        s1_acos_r;
  lpft_pkg::side_t    s1_side_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_rok_r  <= s0_rok_r;
      s1_dist_r <= s0_dist_r;
      s1_asin_r <= s0_asin_r;
      s1_acos_r <= (s0_asin_r >= lpft_pkg::THREE_QUARTER) ?
                   s0_asin_r - lpft_pkg::THREE_QUARTER : s0_asin_r + lpft_pkg::QUARTER_TURN;
      s1_side_r <= s0_side_r;
    end
  end

  // stage 2: quadrant fold to rom addresses
  logic               s2_rok_r;
  logic [15:0]        s2_dist_r;
  quad_t              s2_qsin_r;
  quad_t              s2_qcos_r;
  lpft_pkg::side_t    s2_side_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_rok_r  <= s1_rok_r;
      s2_dist_r <= s1_dist_r;
      s2_qsin_r <= quad_of(s1_asin_r);
      s2_qcos_r <= quad_of(s1_acos_r);
      s2_side_r <= s1_side_r;
    end
  end

  // stage 3: sine rom, two registered read ports
  logic                         s3_rok_r;
  logic [15:0]                  s3_dist_r;
  logic [lpft_pkg::SINE_W-1:0]  s3_sin_r;
  logic [lpft_pkg::SINE_W-1:0]  s3_cos_r;
  logic                         s3_nsin_r;
  logic                         s3_ncos_r;
  lpft_pkg::side_t              s3_side_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_rok_r  <= s2_rok_r;
      s3_dist_r <= s2_dist_r;
      s3_sin_r  <= sine_rom[s2_qsin_r.idx];
      s3_cos_r  <= sine_rom[s2_qcos_r.idx];
      s3_nsin_r <= s2_qsin_r.neg;
      s3_ncos_r <= s2_qcos_r.neg;
      s3_side_r <= s2_side_r;
    end
  end

  // stage 4: sensor-frame x and y in q15 mm
  logic signed [15:0] sin_val;
  logic signed [15:0] cos_val;
  logic signed [16:0] dist_s;

  assign sin_val = s3_nsin_r ? -signed'({1'b0, s3_sin_r}) : signed'({1'b0, s3_sin_r});
  assign cos_val = s3_ncos_r ? -signed'({1'b0, s3_cos_r}) : signed'({1'b0, s3_cos_r});
  assign dist_s  = signed'({1'b0, s3_dist_r});

  logic                             s4_rok_r;
  logic signed [lpft_pkg::XY_W-1:0] s4_xs_r;
  logic signed [lpft_pkg::XY_W-1:0] s4_ys_r;
  lpft_pkg::side_t                  s4_side_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_rok_r  <= s3_rok_r;
      s4_xs_r   <= dist_s * cos_val;
      s4_ys_r   <= dist_s * sin_val;
      s4_side_r <= s3_side_r;
    end
  end

  // stage 5: rotation products
  logic                               s5_rok_r;
  logic signed [lpft_pkg::PROD_W-1:0] s5_prod_r [6];
  lpft_pkg::side_t                    s5_side_r;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_rok_r     <= s4_rok_r;
      s5_prod_r[0] <= signed'(rot_xy_r[15:0])  * s4_xs_r;
      s5_prod_r[1] <= signed'(rot_xy_r[31:16]) * s4_ys_r;
      s5_prod_r[2] <= signed'(rot_xy_r[47:32]) * s4_xs_r;
      s5_prod_r[3] <= signed'(rot_xy_r[63:48]) * s4_ys_r;
      s5_prod_r[4] <= signed'(rot_z_r[15:0])   * s4_xs_r;
      s5_prod_r[5] <= signed'(rot_z_r[31:16])  * s4_ys_r;
      s5_side_r    <= s4_side_r;
    end
  end

  // stage 6: axis sums, translation and rounding to mm
  logic signed [lpft_pkg::SUM_W-1:0] sum_x;
  logic signed [lpft_pkg::SUM_W-1:0] sum_y;
  logic signed [lpft_pkg::SUM_W-1:0] sum_z;

  assign sum_x = lpft_pkg::SUM_W'(s5_prod_r[0]) + lpft_pkg::SUM_W'(s5_prod_r[1]) +
                 bias_of(offset_r[15:0]);
  assign sum_y = lpft_pkg::SUM_W'(s5_prod_r[2]) + lpft_pkg::SUM_W'(s5_prod_r[3]) +
                 bias_of(offset_r[31:16]);
  assign sum_z = lpft_pkg::SUM_W'(s5_prod_r[4]) + lpft_pkg::SUM_W'(s5_prod_r[5]) +
                 bias_of(offset_r[47:32]);

  logic                              s6_rok_r;
  logic signed [lpft_pkg::POS_W-1:0] s6_px_r;
  logic signed [lpft_pkg::POS_W-1:0] s6_py_r;
  logic signed [lpft_pkg::POS_W-1:0] s6_pz_r;
  lpft_pkg::side_t                   s6_side_r;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_rok_r  <= s5_rok_r;
      s6_px_r   <= sum_x[lpft_pkg::SUM_W-1:lpft_pkg::FRAC_W];
      s6_py_r   <= sum_y[lpft_pkg::SUM_W-1:lpft_pkg::FRAC_W];
      s6_pz_r   <= sum_z[lpft_pkg::SUM_W-1:lpft_pkg::FRAC_W];
      s6_side_r <= s5_side_r;
    end
  end

  // stage 7: body box test on unsaturated values, saturation, output register
  logic body_hit;

  assign body_hit = (s6_px_r > signed'(box_x_r[15:0])) &&
                    (s6_px_r < signed'(box_x_r[31:16])) &&
                    (s6_py_r > signed'(box_y_r[15:0])) &&
                    (s6_py_r < signed'(box_y_r[31:16]));

  logic               s7_keep_r;
  logic signed [15:0] s7_x_r;
  logic signed [15:0] s7_y_r;
  logic signed [15:0] s7_z_r;
  lpft_pkg::side_t    s7_side_r;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s7_keep_r <= s6_rok_r && !body_hit;
      s7_x_r    <= s6_rok_r ? sat16(s6_px_r) : '0;
      s7_y_r    <= s6_rok_r ? sat16(s6_py_r) : '0;
      s7_z_r    <= s6_rok_r ? sat16(s6_pz_r) : '0;
      s7_side_r <= s6_side_r;
    end
  end

  assign out_pt.valid           = vld_r[NSTG-1];
  assign out_pt.keep            = s7_keep_r;
  assign out_pt.pos_x_mm        = s7_x_r;
  assign out_pt.pos_y_mm        = s7_y_r;
  assign out_pt.pos_z_mm        = s7_z_r;
  assign out_pt.reflectance_out = s7_side_r.reflectance;
  assign out_pt.index_out       = s7_side_r.point_index;
  assign out_pt.last_out        = s7_side_r.last_point;

endmodule

### test/lidar_point_filter_transform_top_tb.sv
// Testbench for lidar_point_filter_transform_top: random and directed lidar returns
// are checked against an in-bench predictor of range filter, transform and body box.
// Depends on lpft_pkg and the lpft_if channel interfaces.
`timescale 1ns / 1ps

module lidar_point_filter_transform_top_tb;

  localparam logic [63:0] Q30_PI      = 64'd3373259426;
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          LONG_HOLD   = 80;

  typedef struct packed {
    logic [15:0] distance_mm;
    logic [15:0] angle_centideg;
    logic [7:0]  reflectance;
    logic [9:0]  point_index;
    logic        last_point;
  } lidar_return_t;

  typedef struct packed {
    logic        keep;
    logic [15:0] pos_x_mm;
    logic [15:0] pos_y_mm;
    logic [15:0] pos_z_mm;
    logic [7:0]  reflectance_out;
    logic [9:0]  index_out;
    logic        last_out;
  } filtered_point_t;

  logic clk = 1'b0;
  logic rst_n;

  lpft_in_if  in_pt ();
  lpft_out_if out_pt ();
  lpft_cfg_if cfg_wr ();

  lidar_point_filter_transform_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pt  (in_pt),
    .out_pt (out_pt),
    .cfg_wr (cfg_wr)
  );

  // register image as the block should hold it
  logic [15:0] min_range_cfg;
  logic [15:0] max_range_cfg;
  logic [31:0] box_x_cfg;
  logic [31:0] box_y_cfg;
  logic [63:0] rot_xy_cfg;
  logic [31:0] rot_z_cfg;
  logic [47:0] offset_cfg;

  lidar_return_t   pending_returns[$];
  filtered_point_t expected_points[$];
  lidar_return_t   taken_return;
  filtered_point_t seen_point;
  filtered_point_t want_point;

  int fail_count  = 0;
  int cycle_count = 0;
  int tx_gap      = 0;
  int rx_gap      = 0;
  bit in_taken    = 1'b0;
  bit idle_en     = 1'b1;
  bit hold_go     = 1'b0;
  bit rx_blocked  = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // sin of k/100 degree for k in 0..9000 by the truncated series, q1.15
  function automatic longint quarter_wave_q15(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (64'(k) * Q30_PI) / 64'd18000;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return longint'(s);
  endfunction

  function automatic longint sine_centideg(input int unsigned a);
    int unsigned q;
    int unsigned r;
    a = a % lpft_pkg::FULL_TURN;
    q = a / lpft_pkg::QUARTER_TURN;
    r = a % lpft_pkg::QUARTER_TURN;
    case (q)
      0: return quarter_wave_q15(r);
      1: return quarter_wave_q15(lpft_pkg::QUARTER_TURN - r);
      2: return -quarter_wave_q15(r);
      default: return -quarter_wave_q15(lpft_pkg::QUARTER_TURN - r);
    endcase
  endfunction

  function automatic longint lane_s16(input logic [63:0] word, input int lane);
    return longint'($signed(word[16*lane +: 16]));
  endfunction

  // q29 mm to whole mm, ties go up
  function automatic longint q29_to_mm(input longint v);
    return (v + (longint'(1) << 28)) >>> 29;
  endfunction

  function automatic logic [15:0] sat_s16(input longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic filtered_point_t filter_point(input lidar_return_t r);
    filtered_point_t p;
    longint xs;
    longint ys;
    longint px;
    longint py;
    longint pz;
    bit body_hit;
    p = '0;
    p.reflectance_out = r.reflectance;
    p.index_out       = r.point_index;
    p.last_out        = r.last_point;
    if (r.distance_mm >= min_range_cfg && r.distance_mm <= max_range_cfg) begin
      xs = longint'(r.distance_mm) *
           sine_centideg(int'(r.angle_centideg) + int'(lpft_pkg::QUARTER_TURN));
      ys = longint'(r.distance_mm) * sine_centideg(int'(r.angle_centideg));
      px = q29_to_mm(lane_s16(rot_xy_cfg, 0) * xs + lane_s16(rot_xy_cfg, 1) * ys +
                     (lane_s16(64'(offset_cfg), 0) <<< 29));
      py = q29_to_mm(lane_s16(rot_xy_cfg, 2) * xs + lane_s16(rot_xy_cfg, 3) * ys +
                     (lane_s16(64'(offset_cfg), 1) <<< 29));
      pz = q29_to_mm(lane_s16(64'(rot_z_cfg), 0) * xs + lane_s16(64'(rot_z_cfg), 1) * ys +
                     (lane_s16(64'(offset_cfg), 2) <<< 29));
      body_hit = px > lane_s16(64'(box_x_cfg), 0) && px < lane_s16(64'(box_x_cfg), 1) &&
                 py > lane_s16(64'(box_y_cfg), 0) && py < lane_s16(64'(box_y_cfg), 1);
      p.keep     = !body_hit;
      p.pos_x_mm = sat_s16(px);
      p.pos_y_mm = sat_s16(py);
      p.pos_z_mm = sat_s16(pz);
    end
    return p;
  endfunction

  function automatic logic [31:0] box_span(input int lo, input int hi);
    return {16'(hi), 16'(lo)};
  endfunction

  function automatic logic [15:0] random_coeff();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 32768)) - 16'd16384;
  endfunction

  function automatic logic [15:0] random_offset();
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 4000)) - 16'd2000;
  endfunction

  task automatic write_reg(input logic [lpft_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] data);
    @(negedge clk);
    cfg_wr.valid    <= 1'b1;
    cfg_wr.wr_index <= idx;
    cfg_wr.wr_data  <= data;
    do @(posedge clk); while (!cfg_wr.ready);
    case (idx)
      lpft_pkg::CFG_MIN_RANGE: min_range_cfg = data[15:0];
      lpft_pkg::CFG_MAX_RANGE: max_range_cfg = data[15:0];
      lpft_pkg::CFG_BOX_X:     box_x_cfg     = data[31:0];
      lpft_pkg::CFG_BOX_Y:     box_y_cfg     = data[31:0];
      lpft_pkg::CFG_ROT_XY:    rot_xy_cfg    = data;
      lpft_pkg::CFG_ROT_Z:     rot_z_cfg     = data[31:0];
      lpft_pkg::CFG_OFFSET:    offset_cfg    = data[47:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr.valid <= 1'b0;
  endtask

  task automatic load_setup(input logic [15:0] lo, input logic [15:0] hi,
                            input logic [31:0] bx, input logic [31:0] by,
                            input logic [63:0] rxy, input logic [31:0] rz,
                            input logic [47:0] off);
    write_reg(lpft_pkg::CFG_MIN_RANGE, 64'(lo));
    write_reg(lpft_pkg::CFG_MAX_RANGE, 64'(hi));
    write_reg(lpft_pkg::CFG_BOX_X, 64'(bx));
    write_reg(lpft_pkg::CFG_BOX_Y, 64'(by));
    write_reg(lpft_pkg::CFG_ROT_XY, rxy);
    write_reg(lpft_pkg::CFG_ROT_Z, 64'(rz));
    write_reg(lpft_pkg::CFG_OFFSET, 64'(off));
  endtask

  task automatic random_setup();
    logic [15:0] lo;
    logic [15:0] hi;
    logic [63:0] rxy;
    int bx0;
    int bx1;
    int by0;
    int by1;
    lo = 16'($urandom_range(0, 1500));
    hi = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, lo))
                                     : 16'($urandom_range(lo, 65535));
    for (int i = 0; i < 4; i++) begin
      rxy[16*i +: 16] = random_coeff();
    end
    bx0 = -int'($urandom_range(0, 3000));
    bx1 = $urandom_range(0, 3000);
    by0 = -int'($urandom_range(0, 3000));
    by1 = $urandom_range(0, 3000);
    if ($urandom_range(0, 7) == 0) begin
      // inverted box, never hit
      bx0 = bx1 + 1;
    end
    load_setup(lo, hi, box_span(bx0, bx1), box_span(by0, by1), rxy,
               {random_coeff(), random_coeff()},
               {random_offset(), random_offset(), random_offset()});
  endtask

  task automatic queue_return(input logic [15:0] d, input logic [15:0] a,
                              input logic [7:0] refl, input logic [9:0] idx,
                              input logic last);
    lidar_return_t r;
    r.distance_mm    = d;
    r.angle_centideg = a;
    r.reflectance    = refl;
    r.point_index    = idx;
    r.last_point     = last;
    pending_returns  = {pending_returns, r};
  endtask

  task automatic queue_random_returns(input int n);
    int pick;
    logic [15:0] d;
    logic [15:0] a;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70 && min_range_cfg <= max_range_cfg) begin
        d = 16'($urandom_range(min_range_cfg, max_range_cfg));
      end else if (pick < 85) begin
        case ($urandom_range(0, 3))
          0: d = min_range_cfg - 16'd1;
          1: d = min_range_cfg;
          2: d = max_range_cfg;
          default: d = max_range_cfg + 16'd1;
        endcase
      end else begin
        d = 16'($urandom);
      end
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        a = 16'($urandom_range(0, 35999));
      end else if (pick < 95) begin
        // around the quadrant boundaries
        a = 16'(9000 * $urandom_range(0, 4) + $urandom_range(0, 2)) - 16'd1;
      end else begin
        a = 16'($urandom_range(36000, 65535));
      end
      queue_return(d, a, 8'($urandom), 10'($urandom), $urandom_range(0, 15) == 0);
    end
  endtask

  task automatic wait_drained();
    while (pending_returns.size() != 0 || expected_points.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // sender: offered request is held until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_pt.valid <= 1'b0;
    end else if (in_pt.valid && !in_taken) begin
      in_pt.valid <= 1'b1;
    end else if (tx_gap > 0) begin
      tx_gap--;
      in_pt.valid <= 1'b0;
    end else if (pending_returns.size() == 0) begin
      in_pt.valid <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      tx_gap = $urandom_range(0, 5);
      in_pt.valid <= 1'b0;
    end else begin
      in_pt.valid          <= 1'b1;
      in_pt.distance_mm    <= pending_returns[0].distance_mm;
      in_pt.angle_centideg <= pending_returns[0].angle_centideg;
      in_pt.reflectance    <= pending_returns[0].reflectance;
      in_pt.point_index    <= pending_returns[0].point_index;
      in_pt.last_point     <= pending_returns[0].last_point;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n || rx_blocked) begin
      out_pt.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_pt.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(0, 5);
      out_pt.ready <= 1'b0;
    end else begin
      out_pt.ready <= 1'b1;
    end
  end

  // long receiver hold-off so the pipeline fills and backs up the input
  initial begin
    wait (hold_go);
    rx_blocked = 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    rx_blocked = 1'b0;
  end

  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n && in_pt.valid && in_pt.ready) begin
      taken_return    = pending_returns.pop_front();
      expected_points = {expected_points, filter_point(taken_return)};
      in_taken = 1'b1;
    end
    if (rst_n && out_pt.valid && out_pt.ready) begin
      seen_point.keep            = out_pt.keep;
      seen_point.pos_x_mm        = out_pt.pos_x_mm;
      seen_point.pos_y_mm        = out_pt.pos_y_mm;
      seen_point.pos_z_mm        = out_pt.pos_z_mm;
      seen_point.reflectance_out = out_pt.reflectance_out;
      seen_point.index_out       = out_pt.index_out;
      seen_point.last_out        = out_pt.last_out;
      if (expected_points.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected point: keep=%0b x=%0d y=%0d z=%0d idx=%0d",
                   seen_point.keep, $signed(seen_point.pos_x_mm),
                   $signed(seen_point.pos_y_mm), $signed(seen_point.pos_z_mm),
                   seen_point.index_out);
        end
      end else begin
        want_point = expected_points.pop_front();
        if (seen_point.keep !== want_point.keep ||
            seen_point.pos_x_mm !== want_point.pos_x_mm ||
            seen_point.pos_y_mm !== want_point.pos_y_mm ||
            seen_point.pos_z_mm !== want_point.pos_z_mm ||
            seen_point.reflectance_out !== want_point.reflectance_out ||
            seen_point.index_out !== want_point.index_out ||
            seen_point.last_out !== want_point.last_out) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display({"point mismatch want: keep=%0b x=%0d y=%0d z=%0d",
                      " rssi=%0d idx=%0d last=%0b"},
                     want_point.keep, $signed(want_point.pos_x_mm),
                     $signed(want_point.pos_y_mm), $signed(want_point.pos_z_mm),
                     want_point.reflectance_out, want_point.index_out,
                     want_point.last_out);
            $display({"               got:  keep=%0b x=%0d y=%0d z=%0d",
                      " rssi=%0d idx=%0d last=%0b"},
                     seen_point.keep, $signed(seen_point.pos_x_mm),
                     $signed(seen_point.pos_y_mm), $signed(seen_point.pos_z_mm),
                     seen_point.reflectance_out, seen_point.index_out,
                     seen_point.last_out);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n                = 1'b0;
    cfg_wr.valid         = 1'b0;
    cfg_wr.wr_index      = '0;
    cfg_wr.wr_data       = '0;
    min_range_cfg        = lpft_pkg::RST_MIN_RANGE;
    max_range_cfg        = lpft_pkg::RST_MAX_RANGE;
    box_x_cfg            = '0;
    box_y_cfg            = '0;
    rot_xy_cfg           = lpft_pkg::RST_ROT_XY;
    rot_z_cfg            = '0;
    offset_cfg           = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: range edges, saturation, quadrants, angles past a full turn
    queue_return(16'd0, 16'd0, 8'd0, 10'd0, 1'b0);
    queue_return(16'd99, 16'd4500, 8'd255, 10'd1023, 1'b1);
    queue_return(16'd100, 16'd0, 8'd255, 10'd1023, 1'b1);
    queue_return(16'd65535, 16'd0, 8'd1, 10'd1, 1'b0);
    queue_return(16'd65535, 16'd18000, 8'd2, 10'd2, 1'b0);
    queue_return(16'd65535, 16'd9000, 8'd3, 10'd512, 1'b0);
    queue_return(16'd65535, 16'd27000, 8'd4, 10'd511, 1'b0);
    queue_return(16'd1000, 16'd35999, 8'd128, 10'd3, 1'b0);
    queue_return(16'd1000, 16'd36000, 8'd127, 10'd4, 1'b0);
    queue_return(16'd1000, 16'd65535, 8'd85, 10'd5, 1'b0);
    queue_return(16'd12345, 16'd13500, 8'd170, 10'd6, 1'b1);
    wait_drained();

    // quarter-turn mount with offset and a body box
    load_setup(16'd500, 16'd20000, box_span(-800, 800), box_span(-800, 800),
               64'h0000_4000_C000_0000, 32'hE000_2000, 48'h04B0_FFCE_0096);
    queue_return(16'd500, 16'd0, 8'd10, 10'd7, 1'b0);
    queue_return(16'd499, 16'd0, 8'd11, 10'd8, 1'b0);
    queue_return(16'd790, 16'd0, 8'd12, 10'd9, 1'b0);
    queue_return(16'd850, 16'd0, 8'd13, 10'd10, 1'b0);  // lands on the box edge
    queue_return(16'd20000, 16'd9000, 8'd14, 10'd11, 1'b0);
    queue_return(16'd20001, 16'd9000, 8'd15, 10'd12, 1'b1);
    queue_random_returns(80);
    wait_drained();

    // single-value window, full-scale coefficients, inverted box in x
    load_setup(16'd1000, 16'd1000, box_span(800, -800), box_span(-32768, 32767),
               64'h7FFF_7FFF_7FFF_7FFF, 32'h8000_8000, 48'h7FFF_8000_7FFF);
    queue_return(16'd999, 16'd3000, 8'd20, 10'd13, 1'b0);
    queue_return(16'd1000, 16'd3000, 8'd21, 10'd14, 1'b0);
    queue_return(16'd1001, 16'd3000, 8'd22, 10'd15, 1'b0);
    queue_random_returns(30);
    wait_drained();

    // most negative x/y coefficients, full-scale z coefficients, box spanning the whole s16 range
    load_setup(16'd0, 16'd65535, box_span(-32768, 32767), box_span(-32768, 32767),
               64'h8000_8000_8000_8000, 32'h7FFF_7FFF, 48'h8000_7FFF_8000);
    queue_return(16'd0, 16'd0, 8'd30, 10'd16, 1'b0);
    queue_random_returns(30);
    wait_drained();

    // inverted range window drops everything
    load_setup(16'd65535, 16'd0, box_span(-500, 500), box_span(-500, 500),
               lpft_pkg::RST_ROT_XY, 32'h0, 48'h0);
    queue_random_returns(15);
    wait_drained();

    for (int i = 0; i < 4; i++) begin
      random_setup();
      queue_random_returns(35);
      wait_drained();
    end

    random_setup();
    hold_go = 1'b1;
    queue_random_returns(70);
    wait_drained();

    idle_en = 1'b0;
    random_setup();
    queue_random_returns(40);
    wait_drained();

    repeat (16) @(posedge clk);
    fail_count += expected_points.size();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
